// ===== rtl/core/stun_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// STUN parser package
// Request and record types, record kinds and attribute type codes shared by
// the STUN message parser.
// ----------------------------------------------------------------------------
package stun_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int MAX_TEXT     = 128;
    localparam int HASH_LEN     = 20;
    localparam int ADDR_LEN     = 8;
    localparam int WORD_LEN     = 4;
    localparam logic [7:0] IPV4_FAMILY = 8'd1;

    localparam logic [15:0] ATTR_MAPPED_ADDRESS     = 16'd1;
    localparam logic [15:0] ATTR_RESPONSE_ADDRESS   = 16'd2;
    localparam logic [15:0] ATTR_CHANGE_REQUEST     = 16'd3;
    localparam logic [15:0] ATTR_SOURCE_ADDRESS     = 16'd4;
    localparam logic [15:0] ATTR_CHANGED_ADDRESS    = 16'd5;
    localparam logic [15:0] ATTR_USERNAME           = 16'd6;
    localparam logic [15:0] ATTR_PASSWORD           = 16'd7;
    localparam logic [15:0] ATTR_MESSAGE_INTEGRITY  = 16'd8;
    localparam logic [15:0] ATTR_ERROR_CODE         = 16'd9;
    localparam logic [15:0] ATTR_UNKNOWN_ATTRIBUTES = 16'd10;
    localparam logic [15:0] ATTR_REFLECTED_FROM     = 16'd11;

    typedef enum logic [3:0] {
        REC_HEADER    = 4'd0,
        REC_ADDR      = 4'd1,
        REC_CHGREQ    = 4'd2,
        REC_USER      = 4'd3,
        REC_PASS      = 4'd4,
        REC_ERR       = 4'd5,
        REC_ERRTEXT   = 4'd6,
        REC_UNKNOWN   = 4'd7,
        REC_INTEGRITY = 4'd8,
        REC_END       = 4'd9,
        REC_TRUNCATED = 4'd10
    } rec_kind_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       buffer_end;
    } byte_req_t;

    typedef struct packed {
        rec_kind_t   rec_kind;
        logic [15:0] type_code;
        logic [31:0] word_value;
        logic [15:0] port_num;
        logic [7:0]  pad_byte;
        logic [7:0]  data_byte;
        logic [7:0]  err_group;
        logic [7:0]  err_number;
        logic        last_of_run;
    } rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/stun_message_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// STUN message parser
// Parses a STUN message one byte per request and emits header, attribute,
// end and truncation records through a four-entry record queue.
// ----------------------------------------------------------------------------
// The records of an accepted byte are written into the queue and offered from its
// head. Throughput: one byte per cycle unless the byte port stalls; a byte that yields
// two records fills two queue entries, and the four-entry queue absorbs the extra one.
// The byte port stalls while fewer than two queue entries are free.
// Reset clears the parse state and empties the queue; the next byte starts a
// new message.
module stun_message_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire stun_pkg::byte_req_t byte_data,
    output logic                   rec_valid,
    input  wire logic              rec_stall,
    output stun_pkg::rec_t         rec_data
);
    import stun_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_AHDR   = 4'b0010,
        PH_VALUE  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [4:0] HDR_LAST = 5'(HEADER_BYTES - 1);

    phase_t      phase_reg, phase_next;
    logic [4:0]  hc_reg, hc_next;
    logic [15:0] msg_type_reg, msg_type_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] atype_reg, atype_next;
    logic [15:0] alen_reg, alen_next;
    logic [15:0] acount_reg, acount_next;
    logic [63:0] acc_reg, acc_next;

    rec_t        queue_reg [QUEUE_DEPTH];
    logic [1:0]  head_reg, tail_reg;
    logic [2:0]  count_reg;

    logic        accept, pop;
    logic [63:0] acc_shift;
    logic        consumed, prim_valid, end_valid, trunc_valid, second_valid;
    logic [15:0] rem_dec;
    rec_t        prim, second, rec0, rec1;
    logic [1:0]  rec_count;
    logic [7:0]  b;

    assign accept     = byte_valid && !byte_stall;
    assign pop        = rec_valid && !rec_stall;
    assign byte_stall = count_reg > 3'(QUEUE_DEPTH - 2);
    assign rec_valid  = count_reg != 3'd0;
    assign rec_data   = queue_reg[head_reg];
    assign b          = byte_data.byte_in;
    assign acc_shift  = {acc_reg[55:0], b};
    assign rem_dec    = (rem_reg != 16'd0) ? rem_reg - 16'd1 : 16'd0;

    always_comb
    begin
        phase_next    = phase_reg;
        hc_next       = hc_reg;
        msg_type_next = msg_type_reg;
        rem_next      = rem_reg;
        atype_next    = atype_reg;
        alen_next     = alen_reg;
        acount_next   = acount_reg;
        acc_next      = acc_reg;
        consumed      = 1'b0;
        prim_valid    = 1'b0;
        end_valid     = 1'b0;
        prim          = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                acc_next = acc_shift;
                if (hc_reg == 5'd1)
                begin
                    msg_type_next = acc_shift[15:0];
                end
                if (hc_reg == 5'd3)
                begin
                    rem_next = acc_shift[15:0];
                end
                if (hc_reg >= HDR_LAST)
                begin
                    prim_valid      = 1'b1;
                    prim.rec_kind   = REC_HEADER;
                    prim.type_code  = msg_type_reg;
                    prim.word_value = {16'd0, rem_reg};
                    hc_next         = 5'd0;
                    acc_next        = '0;
                    if (rem_reg == 16'd0)
                    begin
                        end_valid  = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_AHDR;
                    end
                end
                else
                begin
                    hc_next = hc_reg + 5'd1;
                end
            end
            PH_AHDR:
            begin
                acc_next = acc_shift;
                consumed = 1'b1;
                if (hc_reg >= 5'd3)
                begin
                    atype_next  = acc_shift[31:16];
                    alen_next   = acc_shift[15:0];
                    acount_next = 16'd0;
                    hc_next     = 5'd0;
                    acc_next    = '0;
                    if (acc_shift[15:0] != 16'd0)
                    begin
                        phase_next = PH_VALUE;
                    end
                end
                else
                begin
                    hc_next = hc_reg + 5'd1;
                end
            end
            PH_VALUE:
            begin
                acc_next = acc_shift;
                consumed = 1'b1;
                case (atype_reg) inside
                    ATTR_MAPPED_ADDRESS, ATTR_RESPONSE_ADDRESS, ATTR_SOURCE_ADDRESS,
                    ATTR_CHANGED_ADDRESS, ATTR_REFLECTED_FROM:
                    begin
                        if (alen_reg == 16'(ADDR_LEN) && acount_reg == 16'd7
                            && acc_shift[55:48] == IPV4_FAMILY)
                        begin
                            prim_valid      = 1'b1;
                            prim.rec_kind   = REC_ADDR;
                            prim.type_code  = atype_reg;
                            prim.word_value = acc_shift[31:0];
                            prim.port_num   = acc_shift[47:32];
                            prim.pad_byte   = acc_shift[63:56];
                        end
                    end
                    ATTR_CHANGE_REQUEST:
                    begin
                        if (alen_reg == 16'(WORD_LEN) && acount_reg == 16'd3)
                        begin
                            prim_valid      = 1'b1;
                            prim.rec_kind   = REC_CHGREQ;
                            prim.type_code  = atype_reg;
                            prim.word_value = acc_shift[31:0];
                        end
                    end
                    ATTR_USERNAME, ATTR_PASSWORD:
                    begin
                        if (alen_reg < 16'(MAX_TEXT) && alen_reg[1:0] == 2'd0)
                        begin
                            prim_valid     = 1'b1;
                            prim.rec_kind  = (atype_reg == ATTR_USERNAME) ? REC_USER
                                                                          : REC_PASS;
                            prim.type_code = atype_reg;
                            prim.data_byte = b;
                        end
                    end
                    ATTR_MESSAGE_INTEGRITY:
                    begin
                        if (acount_reg < 16'(HASH_LEN))
                        begin
                            prim_valid     = 1'b1;
                            prim.rec_kind  = REC_INTEGRITY;
                            prim.type_code = atype_reg;
                            prim.data_byte = b;
                        end
                    end
                    ATTR_ERROR_CODE:
                    begin
                        if (alen_reg >= 16'd4 && alen_reg < 16'(MAX_TEXT))
                        begin
                            if (acount_reg == 16'd3)
                            begin
                                prim_valid      = 1'b1;
                                prim.rec_kind   = REC_ERR;
                                prim.type_code  = atype_reg;
                                prim.err_group  = acc_shift[15:8];
                                prim.err_number = acc_shift[7:0];
                            end
                            else if (acount_reg >= 16'd4)
                            begin
                                prim_valid     = 1'b1;
                                prim.rec_kind  = REC_ERRTEXT;
                                prim.type_code = atype_reg;
                                prim.data_byte = b;
                            end
                        end
                    end
                    ATTR_UNKNOWN_ATTRIBUTES:
                    begin
                        if (alen_reg[1:0] == 2'd0 && acount_reg[0])
                        begin
                            prim_valid     = 1'b1;
                            prim.rec_kind  = REC_UNKNOWN;
                            prim.type_code = acc_shift[15:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
                acount_next = acount_reg + 16'd1;
                if ({1'b0, acount_reg} + 17'd1 >= {1'b0, alen_reg})
                begin
                    phase_next = PH_AHDR;
                    hc_next    = 5'd0;
                    acc_next   = '0;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (consumed)
        begin
            rem_next = rem_dec;
            if (rem_dec == 16'd0)
            begin
                end_valid  = 1'b1;
                phase_next = PH_DONE;
            end
        end

        trunc_valid = byte_data.buffer_end && (phase_next != PH_DONE);

        if (byte_data.buffer_end)
        begin
            phase_next    = PH_HEADER;
            hc_next       = 5'd0;
            msg_type_next = 16'd0;
            rem_next      = 16'd0;
            atype_next    = 16'd0;
            alen_next     = 16'd0;
            acount_next   = 16'd0;
            acc_next      = '0;
        end

        second          = '0;
        second.rec_kind = end_valid ? REC_END : REC_TRUNCATED;
        second_valid    = end_valid || trunc_valid;
        rec_count       = {1'b0, prim_valid} + {1'b0, second_valid};

        rec0 = prim_valid ? prim : second;
        rec1 = second;
        rec0.last_of_run = (rec_count == 2'd1);
        rec1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hc_reg       <= 5'd0;
            msg_type_reg <= 16'd0;
            rem_reg      <= 16'd0;
            atype_reg    <= 16'd0;
            alen_reg     <= 16'd0;
            acount_reg   <= 16'd0;
            acc_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            hc_reg       <= hc_next;
            msg_type_reg <= msg_type_next;
            rem_reg      <= rem_next;
            atype_reg    <= atype_next;
            alen_reg     <= alen_next;
            acount_reg   <= acount_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            if (pop)
            begin
                head_reg <= head_reg + 2'd1;
            end
            if (accept)
            begin
                tail_reg <= tail_reg + rec_count;
            end
            count_reg <= count_reg + (accept ? {1'b0, rec_count} : 3'd0)
                         - (pop ? 3'd1 : 3'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && rec_count != 2'd0)
        begin
            queue_reg[tail_reg] <= rec0;
        end
        if (accept && rec_count == 2'd2)
        begin
            queue_reg[tail_reg + 2'd1] <= rec1;
        end
    end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// STUN message parser testbench
// Feeds byte requests into the parser and checks every record that comes out.
// A short table of directed requests runs first. It covers an empty message,
// trailing bytes and early buffer ends. Random buffers follow, built mostly
// from well-formed messages with every attribute type. Some are cut short,
// some overrun or have trailing bytes, and some are plain noise. A behavioral
// parser inside the bench works out the records that each byte must give.
// ----------------------------------------------------------------------------
module testbench;
    import stun_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ATTR_HDR,
        PH_VALUE,
        PH_DONE
    } parse_phase_t;

    typedef struct packed {
        byte_req_t  req;
        logic       use_model;
        logic [1:0] n_typed;
        rec_t       typed0;
        rec_t       typed1;
    } dir_row_t;

    logic      clk;
    logic      rst_n      = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    byte_req_t byte_data  = '0;
    logic      rec_valid;
    logic      rec_stall  = 1'b0;
    rec_t      rec_data;

    parse_phase_t ps_phase;
    int           ps_hdr_idx;
    logic [15:0]  ps_msg_type;
    logic [15:0]  ps_msg_left;
    logic [15:0]  ps_attr_code;
    logic [15:0]  ps_attr_len;
    logic [15:0]  ps_value_idx;
    logic [63:0]  ps_shift;

    rec_t      due_records[$];
    rec_t      byte_records[$];
    byte_req_t buffer_q[$];
    logic [7:0] body_q[$];
    dir_row_t  dir_rows[$];

    int send_idle_pct  = 30;
    int recv_stall_pct = 68;
    int hold_left      = 0;
    int items_sent     = 0;
    int recs_checked   = 0;
    int mismatches     = 0;

    stun_message_parser u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_data   (rec_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    function automatic rec_t make_rec(rec_kind_t kind, logic [15:0] atype, logic [31:0] word,
                                      logic [15:0] port, logic [7:0] pad, logic [7:0] data,
                                      logic [7:0] cls, logic [7:0] num);
        rec_t r;
        r.rec_kind    = kind;
        r.type_code   = atype;
        r.word_value  = word;
        r.port_num    = port;
        r.pad_byte    = pad;
        r.data_byte   = data;
        r.err_group   = cls;
        r.err_number  = num;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    task automatic clear_parse_state();
        ps_phase     = PH_HEADER;
        ps_hdr_idx   = 0;
        ps_msg_type  = '0;
        ps_msg_left  = '0;
        ps_attr_code = '0;
        ps_attr_len  = '0;
        ps_value_idx = '0;
        ps_shift     = '0;
    endtask

    // Works out the records of one accepted byte and, when asked, queues them as due.
    task automatic parse_byte_records(input byte_req_t req, input logic keep);
        logic [7:0]  b;
        logic        consumed;
        logic [15:0] t;
        logic [15:0] len;
        logic [15:0] idx;
        rec_t        r;
        b        = req.byte_in;
        consumed = 1'b0;
        byte_records.delete();
        case (ps_phase)
            PH_HEADER:
            begin
                ps_shift = {ps_shift[55:0], b};
                if (ps_hdr_idx == 1)
                    ps_msg_type = ps_shift[15:0];
                if (ps_hdr_idx == 3)
                    ps_msg_left = ps_shift[15:0];
                if (ps_hdr_idx + 1 >= HEADER_BYTES)
                begin
                    byte_records.push_back(make_rec(REC_HEADER, ps_msg_type, {16'h0, ps_msg_left},
                                                    '0, '0, '0, '0, '0));
                    ps_hdr_idx = 0;
                    ps_shift   = '0;
                    if (ps_msg_left == 16'h0)
                    begin
                        byte_records.push_back(make_rec(REC_END, '0, '0, '0, '0, '0, '0, '0));
                        ps_phase = PH_DONE;
                    end
                    else
                        ps_phase = PH_ATTR_HDR;
                end
                else
                    ps_hdr_idx++;
            end
            PH_ATTR_HDR:
            begin
                ps_shift = {ps_shift[55:0], b};
                consumed = 1'b1;
                if (ps_hdr_idx >= 3)
                begin
                    ps_attr_code = ps_shift[31:16];
                    ps_attr_len  = ps_shift[15:0];
                    ps_value_idx = '0;
                    ps_hdr_idx   = 0;
                    ps_shift     = '0;
                    if (ps_attr_len != 16'h0)
                        ps_phase = PH_VALUE;
                end
                else
                    ps_hdr_idx++;
            end
            PH_VALUE:
            begin
                ps_shift = {ps_shift[55:0], b};
                t        = ps_attr_code;
                len      = ps_attr_len;
                idx      = ps_value_idx;
                case (t)
                    ATTR_MAPPED_ADDRESS, ATTR_RESPONSE_ADDRESS, ATTR_SOURCE_ADDRESS,
                    ATTR_CHANGED_ADDRESS, ATTR_REFLECTED_FROM:
                        if (len == ADDR_LEN && idx == ADDR_LEN - 1 &&
                            ps_shift[55:48] == IPV4_FAMILY)
                            byte_records.push_back(make_rec(REC_ADDR, t, ps_shift[31:0],
                                                            ps_shift[47:32], ps_shift[63:56],
                                                            '0, '0, '0));
                    ATTR_CHANGE_REQUEST:
                        if (len == WORD_LEN && idx == WORD_LEN - 1)
                            byte_records.push_back(make_rec(REC_CHGREQ, t, ps_shift[31:0],
                                                            '0, '0, '0, '0, '0));
                    ATTR_USERNAME, ATTR_PASSWORD:
                        if (len < MAX_TEXT && len[1:0] == 2'b00)
                            byte_records.push_back(make_rec(t == ATTR_USERNAME ? REC_USER : REC_PASS,
                                                            t, '0, '0, '0, b, '0, '0));
                    ATTR_MESSAGE_INTEGRITY:
                        if (idx < HASH_LEN)
                            byte_records.push_back(make_rec(REC_INTEGRITY, t, '0, '0, '0, b,
                                                            '0, '0));
                    ATTR_ERROR_CODE:
                        if (len >= WORD_LEN && len < MAX_TEXT)
                        begin
                            if (idx == WORD_LEN - 1)
                                byte_records.push_back(make_rec(REC_ERR, t, '0, '0, '0, '0,
                                                                ps_shift[15:8], ps_shift[7:0]));
                            else if (idx >= WORD_LEN)
                                byte_records.push_back(make_rec(REC_ERRTEXT, t, '0, '0, '0, b,
                                                                '0, '0));
                        end
                    ATTR_UNKNOWN_ATTRIBUTES:
                        if (len[1:0] == 2'b00 && idx[0])
                            byte_records.push_back(make_rec(REC_UNKNOWN, ps_shift[15:0], '0, '0,
                                                            '0, '0, '0, '0));
                    default:
                        ;
                endcase
                consumed     = 1'b1;
                ps_value_idx = ps_value_idx + 16'h1;
                if (ps_value_idx >= ps_attr_len)
                begin
                    ps_phase   = PH_ATTR_HDR;
                    ps_hdr_idx = 0;
                    ps_shift   = '0;
                end
            end
            default:
                ;
        endcase
        if (consumed)
        begin
            if (ps_msg_left != 16'h0)
                ps_msg_left = ps_msg_left - 16'h1;
            if (ps_msg_left == 16'h0)
            begin
                byte_records.push_back(make_rec(REC_END, '0, '0, '0, '0, '0, '0, '0));
                ps_phase = PH_DONE;
            end
        end
        if (req.buffer_end)
        begin
            if (ps_phase != PH_DONE)
                byte_records.push_back(make_rec(REC_TRUNCATED, '0, '0, '0, '0, '0, '0, '0));
            clear_parse_state();
        end
        if (byte_records.size() > 0)
        begin
            r             = byte_records.pop_back();
            r.last_of_run = 1'b1;
            byte_records.push_back(r);
        end
        if (keep)
            foreach (byte_records[i])
                due_records.push_back(byte_records[i]);
    endtask

    task automatic add_row(input logic [7:0] b, input logic e, input logic use_model,
                           input logic [1:0] n, input rec_t r0, input rec_t r1);
        dir_row_t row;
        row.req.byte_in    = b;
        row.req.buffer_end = e;
        row.use_model      = use_model;
        row.n_typed        = n;
        row.typed0         = r0;
        row.typed1         = r1;
        dir_rows.push_back(row);
    endtask

    task automatic push_byte(input logic [7:0] b);
        byte_req_t q;
        q.byte_in    = b;
        q.buffer_end = 1'b0;
        buffer_q.push_back(q);
    endtask

    // Builds one receive buffer: usually a whole message, sometimes a damaged one.
    task automatic build_buffer(input int msg_no);
        int          n_attr;
        int          r;
        int          len;
        int          shape;
        int          cut;
        logic        is_addr;
        logic [15:0] atype;
        logic [15:0] mlen;
        byte_req_t   tail;
        body_q.delete();
        buffer_q.delete();
        n_attr = $urandom_range(1, 4);
        for (int a = 0; a < n_attr; a++)
        begin
            r = $urandom_range(13);
            if (a == 0 && msg_no < 11)
                atype = 16'(msg_no + 1);
            else if (r >= 1 && r <= 11)
                atype = 16'(r);
            else if (r == 0)
                atype = 16'h0000;
            else if (r == 12)
                atype = 16'($urandom_range(12, 16'h7FFF));
            else
                atype = 16'($urandom_range(16'h8000, 16'hFFFF));
            r       = $urandom_range(9);
            is_addr = 1'b0;
            case (atype)
                ATTR_MAPPED_ADDRESS, ATTR_RESPONSE_ADDRESS, ATTR_SOURCE_ADDRESS,
                ATTR_CHANGED_ADDRESS, ATTR_REFLECTED_FROM:
                begin
                    is_addr = 1'b1;
                    len     = (r < 7) ? ADDR_LEN : $urandom_range(12);
                end
                ATTR_CHANGE_REQUEST:
                    len = (r < 7) ? WORD_LEN : $urandom_range(9);
                ATTR_USERNAME, ATTR_PASSWORD:
                    len = (r < 7) ? 4 * $urandom_range(8) :
                          (r < 9) ? $urandom_range(1, 33) : MAX_TEXT - 4 + 4 * $urandom_range(2);
                ATTR_MESSAGE_INTEGRITY:
                    len = (r < 7) ? HASH_LEN : $urandom_range(28);
                ATTR_ERROR_CODE:
                    len = (r < 6) ? WORD_LEN + $urandom_range(16) :
                          (r < 8) ? $urandom_range(3) :
                          (r < 9) ? MAX_TEXT - 2 + $urandom_range(3) : WORD_LEN;
                ATTR_UNKNOWN_ATTRIBUTES:
                    len = (r < 7) ? 4 * $urandom_range(4) : $urandom_range(1, 9);
                default:
                    len = $urandom_range(12);
            endcase
            body_q.push_back(atype[15:8]);
            body_q.push_back(atype[7:0]);
            body_q.push_back(len[15:8]);
            body_q.push_back(len[7:0]);
            for (int i = 0; i < len; i++)
                body_q.push_back(8'($urandom_range(255)));
            if (is_addr && len == ADDR_LEN && $urandom_range(3) != 0)
                body_q[body_q.size() - 7] = IPV4_FAMILY;
        end

        shape = $urandom_range(19);
        mlen  = 16'(body_q.size());
        if (shape == 16)
            mlen = 16'($urandom_range(body_q.size() - 1));
        else if (shape == 18)
            mlen = mlen + 16'($urandom_range(1, 8));
        atype = 16'($urandom);
        push_byte(atype[15:8]);
        push_byte(atype[7:0]);
        push_byte(mlen[15:8]);
        push_byte(mlen[7:0]);
        for (int i = 0; i < HEADER_BYTES - 4; i++)
            push_byte(8'($urandom_range(255)));
        foreach (body_q[i])
            push_byte(body_q[i]);
        if (shape == 14 || shape == 15)
            repeat ($urandom_range(1, 5))
                push_byte(8'($urandom_range(255)));
        if (shape == 17)
        begin
            cut = $urandom_range(1, buffer_q.size() - 1);
            while (buffer_q.size() > cut)
                tail = buffer_q.pop_back();
        end
        if (shape == 19)
        begin
            buffer_q.delete();
            repeat ($urandom_range(1, 40))
                push_byte(8'($urandom_range(255)));
        end
        tail            = buffer_q.pop_back();
        tail.buffer_end = 1'b1;
        buffer_q.push_back(tail);
    endtask

    task automatic send_byte(input byte_req_t req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= req;
        do
            @(posedge clk);
        while (byte_stall);
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        byte_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (due_records.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("record %0d %s got %0h want %0h",
                                      recs_checked, name, got, want));
    endtask

    // The receiver holds off for a counted stretch when asked, otherwise stalls at random.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rec_stall <= 1'b1;
            end
            else
                rec_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rec_t want;
        if (rst_n && rec_valid && !rec_stall)
        begin
            if (due_records.size() == 0)
                report_mismatch($sformatf("record %0d kind %0d arrived with none due",
                                          recs_checked, rec_data.rec_kind));
            else
            begin
                want = due_records.pop_front();
                check_field("rec_kind", rec_data.rec_kind, want.rec_kind);
                check_field("type_code", rec_data.type_code, want.type_code);
                check_field("word_value", rec_data.word_value, want.word_value);
                check_field("port_num", rec_data.port_num, want.port_num);
                check_field("pad_byte", rec_data.pad_byte, want.pad_byte);
                check_field("data_byte", rec_data.data_byte, want.data_byte);
                check_field("err_group", rec_data.err_group, want.err_group);
                check_field("err_number", rec_data.err_number, want.err_number);
                check_field("last_of_run", rec_data.last_of_run, want.last_of_run);
            end
            recs_checked++;
        end
    end

    initial
    begin
        rec_t     hdr_rec;
        rec_t     end_rec;
        rec_t     trunc_rec;
        dir_row_t row;
        int       msg_no;
        int       msg_in_phase;
        int       target;

        clear_parse_state();
        hdr_rec               = make_rec(REC_HEADER, 16'hFFFF, '0, '0, '0, '0, '0, '0);
        end_rec               = make_rec(REC_END, '0, '0, '0, '0, '0, '0, '0);
        end_rec.last_of_run   = 1'b1;
        trunc_rec             = make_rec(REC_TRUNCATED, '0, '0, '0, '0, '0, '0, '0);
        trunc_rec.last_of_run = 1'b1;

        // An empty message: type all ones, length zero, alternating id bytes, last two zero.
        add_row(8'hFF, 1'b0, 1'b0, 2'd0, '0, '0);
        add_row(8'hFF, 1'b0, 1'b0, 2'd0, '0, '0);
        add_row(8'h00, 1'b0, 1'b0, 2'd0, '0, '0);
        add_row(8'h00, 1'b0, 1'b0, 2'd0, '0, '0);
        for (int i = 4; i < HEADER_BYTES - 1; i++)
            add_row(i[0] ? 8'hFF : 8'h00, 1'b0, 1'b0, 2'd0, '0, '0);
        add_row(8'h00, 1'b0, 1'b0, 2'd2, hdr_rec, end_rec);
        // A trailing byte closes the buffer quietly; a lone byte with buffer end is truncated.
        add_row(8'h5A, 1'b1, 1'b0, 2'd0, '0, '0);
        add_row(8'hFF, 1'b1, 1'b0, 2'd1, trunc_rec, '0);
        add_row(8'h80, 1'b0, 1'b1, 2'd0, '0, '0);
        add_row(8'h01, 1'b0, 1'b1, 2'd0, '0, '0);
        add_row(8'h7E, 1'b1, 1'b1, 2'd0, '0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_byte(row.req);
            parse_byte_records(row.req, row.use_model);
            if (!row.use_model)
            begin
                if (row.n_typed > 0)
                    due_records.push_back(row.typed0);
                if (row.n_typed > 1)
                    due_records.push_back(row.typed1);
            end
        end
        stop_sending();
        wait_drained();

        msg_no = 0;
        for (int phase_no = 0; phase_no < 3; phase_no++)
        begin
            send_idle_pct  = (phase_no == 0) ? 30 : (phase_no == 1) ? 68 : 0;
            recv_stall_pct = (phase_no == 0) ? 68 : (phase_no == 1) ? 30 : 0;
            target         = items_sent + 400;
            msg_in_phase   = 0;
            while (items_sent < target)
            begin
                if (phase_no != 1 && msg_in_phase == 2)
                    hold_left = 160;
                build_buffer(msg_no);
                foreach (buffer_q[i])
                begin
                    send_byte(buffer_q[i]);
                    parse_byte_records(buffer_q[i], 1'b1);
                end
                msg_no++;
                msg_in_phase++;
            end
            stop_sending();
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
